@@ sv/tea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TEA block cipher package
// Widths, cipher constants, register indexes and the round mixing function.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W      = 32;
    localparam int RCNT_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int BLOCK_W     = 2 * WORD_W;

    localparam int MAX_ROUNDS_DEFAULT = 64;
    localparam int RESET_ROUNDS       = 32;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd4;

    // Operation codes carried in tuser.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // One TEA half-round term: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb).
    function automatic word_t tea_mix(input word_t x, input word_t sum,
                                      input word_t ka, input word_t kb);
        word_t t_shl;
        word_t t_shr;
        t_shl = (x << 4) + ka;
        t_shr = (x >> 5) + kb;
        return t_shl ^ (x + sum) ^ t_shr;
    endfunction

endpackage
`default_nettype wire

@@ sv/tea_block_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TEA block cipher
// Fully unrolled, one block per clock while not stalled, Tiny Encryption Algorithm pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_ channel carries one 64-bit block in s_tdata (left word
//   in the low half) and the operation in s_tuser (0 encrypt, 1 decrypt). The
//   result block leaves on the m_ channel in the same layout, in order.
//   Keys and the round count are written through the cfg_ channel; the user
//   must do it while the block is idle (unenforced). cfg_ready is always high.
// Pipeline and throughput:
//   Every TEA cycle is split into two pipeline stages, one per half-round,
//   after the entry register; a block passes all stages whatever the round
//   count (unused rounds pass the block along). One block is accepted every
//   cycle while s_tready is high; one half-round's adder chain sets the clock.
// Reset:
//   aresetn clears the keys, sets the round count to 32 (or MAX_ROUNDS if
//   smaller) and empties the pipeline.
// Stall:
//   The output register is backed by a one-entry skid buffer. While the skid
//   buffer is empty the pipeline keeps moving and s_tready stays high; when it
//   fills, the pipeline freezes and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
    parameter int MAX_ROUNDS = tea_pkg::MAX_ROUNDS_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tea_pkg::WORD_W-1:0]        cfg_data,
    // Input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tea_pkg::BLOCK_W-1:0]       s_tdata,   // [31:0] left_in, [63:32] right_in
    input  wire logic                              s_tuser,   // [0] opcode
    // Output stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tea_pkg::BLOCK_W-1:0]            m_tdata    // [31:0] left_out, [63:32] right_out
);

    localparam int NUM_STAGES = 2 * MAX_ROUNDS;
    localparam int RESET_RCNT =
        (tea_pkg::RESET_ROUNDS > MAX_ROUNDS) ? MAX_ROUNDS : tea_pkg::RESET_ROUNDS;
    localparam logic [tea_pkg::RCNT_W-1:0] RESET_RCNT_V = tea_pkg::RCNT_W'(RESET_RCNT);
    localparam logic [tea_pkg::RCNT_W-1:0] MAX_RCNT_V   = tea_pkg::RCNT_W'(MAX_ROUNDS);
    localparam tea_pkg::word_t RESET_DEC_SUM =
        tea_pkg::WORD_W'(tea_pkg::TEA_DELTA * tea_pkg::WORD_W'(RESET_RCNT));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    tea_pkg::word_t                 key0_reg, key1_reg, key2_reg, key3_reg;
    logic [tea_pkg::RCNT_W-1:0]     round_count_reg;
    logic [tea_pkg::RCNT_W-1:0]     round_count_next;
    // Starting sum for decryption, delta times the round count.
    tea_pkg::word_t                 dec_sum_reg;
    tea_pkg::word_t                 dec_sum_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (int'(cfg_data[tea_pkg::RCNT_W-1:0]) > MAX_ROUNDS) begin
            round_count_next = MAX_RCNT_V;
        end else begin
            round_count_next = cfg_data[tea_pkg::RCNT_W-1:0];
        end
        dec_sum_next = tea_pkg::TEA_DELTA * tea_pkg::WORD_W'(round_count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg        <= '0;
            key1_reg        <= '0;
            key2_reg        <= '0;
            key3_reg        <= '0;
            round_count_reg <= RESET_RCNT_V;
            dec_sum_reg     <= RESET_DEC_SUM;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tea_pkg::CFG_KEY0: key0_reg <= cfg_data;
                tea_pkg::CFG_KEY1: key1_reg <= cfg_data;
                tea_pkg::CFG_KEY2: key2_reg <= cfg_data;
                tea_pkg::CFG_KEY3: key3_reg <= cfg_data;
                tea_pkg::CFG_ROUNDS: begin
                    round_count_reg <= round_count_next;
                    dec_sum_reg     <= dec_sum_next;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Round pipeline
    // ------------------------------------------------------------------
    logic           vld_reg [0:NUM_STAGES];
    logic           op_reg  [0:NUM_STAGES];
    tea_pkg::word_t y_reg   [0:NUM_STAGES];
    tea_pkg::word_t z_reg   [0:NUM_STAGES];
    tea_pkg::word_t sum_reg [0:NUM_STAGES];

    logic skid_full_reg;
    logic advance;

    assign advance  = !skid_full_reg;
    assign s_tready = !skid_full_reg;

    // Entry stage: encryption uses the sum of the first round directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg[0] <= s_tuser;
            y_reg[0]  <= s_tdata[tea_pkg::WORD_W-1:0];
            z_reg[0]  <= s_tdata[tea_pkg::BLOCK_W-1:tea_pkg::WORD_W];
            sum_reg[0] <= (s_tuser == tea_pkg::OP_DECRYPT) ? dec_sum_reg : tea_pkg::TEA_DELTA;
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        localparam int ROUND  = g / 2;
        localparam bit SECOND = (g % 2) == 1;

        logic           active;
        logic           dec;
        logic           upd_y;
        tea_pkg::word_t src;
        tea_pkg::word_t dst;
        tea_pkg::word_t ka;
        tea_pkg::word_t kb;
        tea_pkg::word_t mix_val;
        tea_pkg::word_t dst_new;
        tea_pkg::word_t sum_new;

        always_comb begin
            active = ROUND < int'(round_count_reg);
            dec    = op_reg[g] == tea_pkg::OP_DECRYPT;
            // Encryption updates left then right; decryption the reverse.
            upd_y  = SECOND ? dec : !dec;
            src    = upd_y ? z_reg[g] : y_reg[g];
            dst    = upd_y ? y_reg[g] : z_reg[g];
            ka     = upd_y ? key0_reg : key2_reg;
            kb     = upd_y ? key1_reg : key3_reg;
            mix_val = tea_pkg::tea_mix(src, sum_reg[g], ka, kb);
            dst_new = dec ? (dst - mix_val) : (dst + mix_val);
            if (SECOND && active) begin
                sum_new = dec ? (sum_reg[g] - tea_pkg::TEA_DELTA)
                              : (sum_reg[g] + tea_pkg::TEA_DELTA);
            end else begin
                sum_new = sum_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (advance) begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                op_reg[g+1]  <= op_reg[g];
                sum_reg[g+1] <= sum_new;
                if (active && upd_y) begin
                    y_reg[g+1] <= dst_new;
                end else begin
                    y_reg[g+1] <= y_reg[g];
                end
                if (active && !upd_y) begin
                    z_reg[g+1] <= dst_new;
                end else begin
                    z_reg[g+1] <= z_reg[g];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid buffer
    // ------------------------------------------------------------------
    logic                          m_tvalid_reg;
    logic [tea_pkg::BLOCK_W-1:0]   m_tdata_reg;
    logic [tea_pkg::BLOCK_W-1:0]   skid_data_reg;
    logic [tea_pkg::BLOCK_W-1:0]   last_data;
    logic                          out_free;

    assign last_data = {z_reg[NUM_STAGES], y_reg[NUM_STAGES]};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (out_free) begin
            m_tvalid_reg <= vld_reg[NUM_STAGES];
        end else if (vld_reg[NUM_STAGES]) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_tready) begin
                m_tdata_reg <= skid_data_reg;
            end
        end else if (out_free) begin
            m_tdata_reg <= last_data;
        end else begin
            skid_data_reg <= last_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A held skid entry always sits behind a pending output result.
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_tvalid_reg)
        else $error("skid buffer full while output register is empty");

    // The skid buffer fills only when the receiver held off a pending result.
    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid buffer filled without an output stall");

    // The stored round count never exceeds MAX_ROUNDS.
    a_round_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(round_count_reg) <= MAX_ROUNDS)
        else $error("round count above MAX_ROUNDS");

    // The decryption start sum follows the round count.
    a_dec_sum_match: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_sum_reg == tea_pkg::WORD_W'(tea_pkg::TEA_DELTA
                                        * tea_pkg::WORD_W'(round_count_reg)))
        else $error("decryption start sum out of step with round count");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// A queue of block and register-write requests feeds a clocked driver. A
// clocked monitor keeps its own copy of the keys and the round count. It
// predicts every accepted block and checks the results in order, while both
// stream sides idle in random bursts, except for the calm requests at the end.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_ROUNDS   = tea_pkg::MAX_ROUNDS_DEFAULT;
    localparam int PIPE_LATENCY = 2 * MAX_ROUNDS + 1;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int BLOCK_TARGET = 1450;
    localparam int CALM_FROM    = 1300;
    localparam int REPORT_MAX   = 10;

    // Register indexes beyond the last defined register are ignored.
    localparam logic [tea_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO =
        tea_pkg::CFG_ROUNDS + tea_pkg::CFG_IDX_W'(1);
    localparam logic [tea_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;
    localparam tea_pkg::word_t ALL_ONES = '1;

    typedef enum logic { REQ_CIPHER, REQ_REG_WRITE } req_kind_t;

    typedef struct {
        req_kind_t                          kind;
        logic                               op;
        tea_pkg::word_t                     left;
        tea_pkg::word_t                     right;
        logic [tea_pkg::CFG_IDX_W-1:0]      idx;
        tea_pkg::word_t                     data;
        logic                               calm;
    } request_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tea_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    tea_pkg::word_t                     cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [tea_pkg::BLOCK_W-1:0]        s_tdata   = '0;   // [31:0] left_in, [63:32] right_in
    logic                               s_tuser   = 1'b0; // [0] opcode
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [tea_pkg::BLOCK_W-1:0]        m_tdata;          // [31:0] left_out, [63:32] right_out

    request_t                           block_requests[$];
    logic [tea_pkg::BLOCK_W-1:0]        cipher_expected[$];

    logic                  s_taken   = 1'b0;
    logic                  cfg_taken = 1'b0;
    logic                  calm_now  = 1'b0;
    int                    send_gap  = 0;
    int                    recv_left = 0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    int                    blocks_queued = 0;

    tea_pkg::word_t                 key_mirror [4];
    logic [tea_pkg::RCNT_W-1:0]     rounds_mirror;

    tea_block_cipher #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic tea_pkg::word_t feistel_term(tea_pkg::word_t x, tea_pkg::word_t s,
                                                    tea_pkg::word_t ka, tea_pkg::word_t kb);
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

    // Returns {right, left} of the transformed block.
    function automatic logic [tea_pkg::BLOCK_W-1:0] tea_transform(
            logic op, tea_pkg::word_t left, tea_pkg::word_t right,
            tea_pkg::word_t k0, tea_pkg::word_t k1, tea_pkg::word_t k2,
            tea_pkg::word_t k3, logic [tea_pkg::RCNT_W-1:0] n);
        tea_pkg::word_t y;
        tea_pkg::word_t z;
        tea_pkg::word_t acc;
        y = left;
        z = right;
        if (op == tea_pkg::OP_ENCRYPT) begin
            acc = '0;
            for (int i = 0; i < n; i++) begin
                acc = acc + tea_pkg::TEA_DELTA;
                y = y + feistel_term(z, acc, k0, k1);
                z = z + feistel_term(y, acc, k2, k3);
            end
        end else begin
            acc = tea_pkg::TEA_DELTA * tea_pkg::word_t'(n);
            for (int i = 0; i < n; i++) begin
                z = z - feistel_term(y, acc, k2, k3);
                y = y - feistel_term(z, acc, k0, k1);
                acc = acc - tea_pkg::TEA_DELTA;
            end
        end
        return {z, y};
    endfunction

    function automatic tea_pkg::word_t rand_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic tea_pkg::word_t pick_round_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 1;
            2: return MAX_ROUNDS;
            3: return MAX_ROUNDS - 1;
            4: return $urandom_range(MAX_ROUNDS + 1, 127);
            5: return $urandom;
            default: return $urandom_range(0, MAX_ROUNDS);
        endcase
    endfunction

    task automatic queue_block(logic op, tea_pkg::word_t left, tea_pkg::word_t right);
        request_t r;
        r.kind  = REQ_CIPHER;
        r.op    = op;
        r.left  = left;
        r.right = right;
        r.idx   = '0;
        r.data  = '0;
        r.calm  = (blocks_queued >= CALM_FROM);
        block_requests.push_back(r);
        blocks_queued++;
    endtask

    task automatic queue_cfg(logic [tea_pkg::CFG_IDX_W-1:0] idx, tea_pkg::word_t data);
        request_t r;
        r.kind  = REQ_REG_WRITE;
        r.op    = tea_pkg::OP_ENCRYPT;
        r.left  = '0;
        r.right = '0;
        r.idx   = idx;
        r.data  = data;
        r.calm  = (blocks_queued >= CALM_FROM);
        block_requests.push_back(r);
    endtask

    // Driver: one request at a time; a register write waits until the
    // pipeline has delivered every outstanding block.
    always @(negedge aclk) begin : drive
        request_t head;
        logic     s_hold;
        logic     c_hold;
        s_hold = s_tvalid && !s_taken;
        c_hold = cfg_valid && !cfg_taken;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else if (s_hold || c_hold) begin
            // Hold the current request until it is taken.
        end else if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else if (block_requests.size() == 0) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else if (block_requests[0].kind == REQ_REG_WRITE) begin
            s_tvalid <= 1'b0;
            if (cipher_expected.size() == 0) begin
                head = block_requests.pop_front();
                calm_now  <= head.calm;
                cfg_valid <= 1'b1;
                cfg_index <= head.idx;
                cfg_data  <= head.data;
            end else begin
                cfg_valid <= 1'b0;
            end
        end else if (!block_requests[0].calm && $urandom_range(0, 7) == 0) begin
            send_gap  <= $urandom_range(0, 10);
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            head = block_requests.pop_front();
            calm_now  <= head.calm;
            cfg_valid <= 1'b0;
            s_tvalid  <= 1'b1;
            s_tdata   <= {head.right, head.left};
            s_tuser   <= head.op;
        end
    end

    always @(negedge aclk) begin : sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_left != 0) begin
            recv_left <= recv_left - 1;
        end else if (calm_now) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready  <= 1'b0;
            recv_left <= $urandom_range(0, 10);
        end else begin
            m_tready  <= 1'b1;
            recv_left <= $urandom_range(0, 40);
        end
    end

    always @(posedge aclk) begin : observe
        logic [tea_pkg::BLOCK_W-1:0] want;
        if (!aresetn) begin
            s_taken   <= 1'b0;
            cfg_taken <= 1'b0;
            for (int i = 0; i < 4; i++) key_mirror[i] = '0;
            rounds_mirror = tea_pkg::RCNT_W'((tea_pkg::RESET_ROUNDS > MAX_ROUNDS) ?
                                             MAX_ROUNDS : tea_pkg::RESET_ROUNDS);
        end else begin
            s_taken   <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tea_pkg::CFG_KEY0:   key_mirror[0] = cfg_data;
                    tea_pkg::CFG_KEY1:   key_mirror[1] = cfg_data;
                    tea_pkg::CFG_KEY2:   key_mirror[2] = cfg_data;
                    tea_pkg::CFG_KEY3:   key_mirror[3] = cfg_data;
                    tea_pkg::CFG_ROUNDS:
                        rounds_mirror = (int'(cfg_data[tea_pkg::RCNT_W-1:0]) > MAX_ROUNDS) ?
                                        tea_pkg::RCNT_W'(MAX_ROUNDS) :
                                        cfg_data[tea_pkg::RCNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cipher_expected.push_back(tea_transform(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                        key_mirror[0], key_mirror[1],
                                                        key_mirror[2], key_mirror[3],
                                                        rounds_mirror));
            end
            if (m_tvalid && m_tready) begin
                if (cipher_expected.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: result with nothing expected: left %h right %h",
                                 $realtime, m_tdata[31:0], m_tdata[63:32]);
                    mismatch_count++;
                end else begin
                    want = cipher_expected.pop_front();
                    if (m_tdata[31:0] !== want[31:0] || m_tdata[63:32] !== want[63:32]) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("%0t: mismatch: left exp %h got %h, right exp %h got %h",
                                     $realtime, want[31:0], m_tdata[31:0],
                                     want[63:32], m_tdata[63:32]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tea_block_cipher");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        // Keys zero and 32 rounds straight out of reset.
        queue_block(tea_pkg::OP_ENCRYPT, '0, '0);
        queue_block(tea_pkg::OP_DECRYPT, '0, '0);
        queue_block(tea_pkg::OP_ENCRYPT, ALL_ONES, ALL_ONES);
        queue_block(tea_pkg::OP_DECRYPT, ALL_ONES, ALL_ONES);
        queue_block(tea_pkg::OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_block(tea_pkg::OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_cfg(tea_pkg::CFG_KEY0, 32'h0123_4567);
        queue_cfg(tea_pkg::CFG_KEY1, 32'h89AB_CDEF);
        queue_cfg(tea_pkg::CFG_KEY2, 32'hFEDC_BA98);
        queue_cfg(tea_pkg::CFG_KEY3, 32'h7654_3210);
        queue_block(tea_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        queue_block(tea_pkg::OP_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        // Zero rounds must pass the block through untouched.
        queue_cfg(tea_pkg::CFG_ROUNDS, '0);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        queue_block(tea_pkg::OP_DECRYPT, $urandom, $urandom);
        // Oversized round counts saturate; bits above the field are dropped.
        queue_cfg(tea_pkg::CFG_ROUNDS, ALL_ONES);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        queue_block(tea_pkg::OP_DECRYPT, $urandom, $urandom);
        queue_cfg(tea_pkg::CFG_ROUNDS, MAX_ROUNDS + 1);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        queue_cfg(tea_pkg::CFG_ROUNDS, 1);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        queue_block(tea_pkg::OP_DECRYPT, $urandom, $urandom);
        // Writes to unused indexes must leave every register alone.
        queue_cfg(CFG_IDX_SPARE_LO, '0);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        queue_cfg(CFG_IDX_SPARE_HI, ALL_ONES);
        queue_block(tea_pkg::OP_DECRYPT, $urandom, $urandom);
        queue_cfg(tea_pkg::CFG_ROUNDS, 32'h0000_0080);
        queue_block(tea_pkg::OP_ENCRYPT, $urandom, $urandom);
        for (int i = 0; i < 4; i++)
            queue_cfg(tea_pkg::CFG_KEY0 + tea_pkg::CFG_IDX_W'(i), ALL_ONES);
        queue_cfg(tea_pkg::CFG_ROUNDS, MAX_ROUNDS);
        queue_block(tea_pkg::OP_ENCRYPT, ALL_ONES, ALL_ONES);
        queue_block(tea_pkg::OP_DECRYPT, ALL_ONES, ALL_ONES);

        while (blocks_queued < BLOCK_TARGET) begin
            for (int i = 0; i < 4; i++)
                if ($urandom_range(0, 1) == 0)
                    queue_cfg(tea_pkg::CFG_KEY0 + tea_pkg::CFG_IDX_W'(i), rand_word());
            queue_cfg(tea_pkg::CFG_ROUNDS, pick_round_data());
            if ($urandom_range(0, 3) == 0)
                queue_cfg(tea_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO,
                                                             CFG_IDX_SPARE_HI)), $urandom);
            n = $urandom_range(60, 140);
            for (int j = 0; j < n && blocks_queued < BLOCK_TARGET; j++)
                queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (block_requests.size() != 0 || s_tvalid || cfg_valid ||
               cipher_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && cipher_expected.size() == 0) begin
            $display("PASS tea_block_cipher");
        end else begin
            $display("FAIL tea_block_cipher");
        end
        $finish;
    end

endmodule
